// File: design/periodic_tick_dispatcher_core_assert.svh
// Assertion macros shared by the RTL. Each expects clk and arst_n in scope.
`ifndef PERIODIC_TICK_DISPATCHER_CORE_ASSERT_SVH
`define PERIODIC_TICK_DISPATCHER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PTD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication that must hold in the following cycle.
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ptd_pkg.sv
`default_nettype none
package ptd_pkg;

	localparam int unsigned SLOTS_DEF = 64;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned STEP_W    = $clog2(DATA_W);
	localparam int unsigned SLOT_W    = 6;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned OUT_W     = 48;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_OVERLAP = 2'd1,
		STATUS_FULL    = 2'd2,
		STATUS_SMALL   = 2'd3
	} status_t;

	typedef enum logic {
		ACT_ADD  = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic    load_item;
		logic    tick_inc;
		logic    rd_en;
		logic    div_start;
		logic    idx_inc;
		logic    set_hit;
		logic    commit;
		logic    set_status;
		status_t status_code;
		logic    out_load;
	} ptd_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic small_period;
		logic tick_zero;
		logic idx_end;
		logic full;
		logic div_done;
		logic rem_zero;
		logic out_free;
	} ptd_sts_t;

endpackage
`default_nettype wire

// File: design/ptd_mod.sv
`default_nettype none
module ptd_mod (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [ptd_pkg::DATA_W-1:0] dividend,
	input  wire logic [ptd_pkg::DATA_W-1:0] divisor,
	output logic                            done,
	output logic                            rem_zero
);
	import ptd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DATA_W-1:0] dvd_q;
	logic [DATA_W-1:0] dsr_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;

	// Restoring remainder, one dividend bit per cycle.
	assign trial = {rem_q, dvd_q[DATA_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
			rem_q <= diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

// File: design/ptd_dp.sv
`default_nettype none
module ptd_dp #(
	parameter int unsigned SLOTS = ptd_pkg::SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ptd_pkg::ptd_cmd_t            cmd,
	output ptd_pkg::ptd_sts_t                 sts,
	input  wire logic                         in_action,
	input  wire logic [ptd_pkg::DATA_W-1:0]   in_period,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic [ptd_pkg::STATUS_W-1:0]      out_status,
	output logic                              out_fired,
	output logic [ptd_pkg::SLOT_W-1:0]        out_slot,
	output logic [ptd_pkg::DATA_W-1:0]        out_elapsed
);
	import ptd_pkg::*;

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(SLOTS + 1);

	logic [DATA_W-1:0] mem [SLOTS];

	logic              action_q;
	logic [DATA_W-1:0] period_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] tick_q;
	logic [DATA_W-1:0] bound_q;
	status_t           status_q;
	logic              hit_q;
	logic [DATA_W-1:0] rd_data_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic              out_fired_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [DATA_W-1:0] out_elapsed_q;

	logic              is_tick;
	logic              wrap;
	logic [DATA_W-1:0] op_dividend;
	logic [DATA_W-1:0] op_divisor;
	logic              div_done;
	logic              rem_zero;

	assign is_tick = (action_q == ACT_TICK);
	assign wrap    = is_tick && (tick_q > bound_q);

	// An add tests the larger of the two periods against the smaller one; a tick
	// tests the counter against the stored half-period.
	always_comb begin
		if (is_tick) begin
			op_dividend = tick_q;
			op_divisor  = {1'b0, rd_data_q[DATA_W-1:1]};
		end else if (rd_data_q > period_q) begin
			op_dividend = rd_data_q;
			op_divisor  = period_q;
		end else begin
			op_dividend = period_q;
			op_divisor  = rd_data_q;
		end
	end

	ptd_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (op_dividend),
		.divisor  (op_divisor),
		.done     (div_done),
		.rem_zero (rem_zero)
	);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			mem[count_q[IDX_W-1:0]] <= period_q;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[idx_q[IDX_W-1:0]];
		end
		if (cmd.load_item) begin
			action_q <= in_action;
			period_q <= in_period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			count_q  <= '0;
			tick_q   <= '0;
			bound_q  <= '0;
			status_q <= STATUS_OK;
			hit_q    <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				idx_q    <= '0;
				status_q <= STATUS_OK;
				hit_q    <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.set_status) begin
				status_q <= cmd.status_code;
			end
			if (cmd.set_hit) begin
				hit_q <= 1'b1;
			end
			if (cmd.tick_inc) begin
				tick_q <= tick_q + 1'b1;
			end else if (cmd.out_load && wrap) begin
				tick_q <= '0;
			end
			if (cmd.commit) begin
				count_q <= count_q + 1'b1;
				if (period_q > bound_q) begin
					bound_q <= period_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q  <= status_q;
			out_fired_q   <= hit_q;
			out_slot_q    <= hit_q ? SLOT_W'(idx_q) : '0;
			out_elapsed_q <= wrap ? '0 : tick_q;
		end
	end

	assign sts.is_tick      = is_tick;
	assign sts.small_period = (period_q[DATA_W-1:1] == '0);
	assign sts.tick_zero    = (tick_q == '0);
	assign sts.idx_end      = (idx_q == count_q);
	assign sts.full         = (count_q == CNT_W'(SLOTS));
	assign sts.div_done     = div_done;
	assign sts.rem_zero     = rem_zero;
	assign sts.out_free     = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_fired   = out_fired_q;
	assign out_slot    = out_slot_q;
	assign out_elapsed = out_elapsed_q;

endmodule
`default_nettype wire

// File: design/ptd_ctrl.sv
`default_nettype none
module ptd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ptd_pkg::ptd_sts_t sts,
	output ptd_pkg::ptd_cmd_t      cmd
);
	import ptd_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt       = state_q;
		cmd             = '0;
		cmd.status_code = STATUS_OK;
		in_ready        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nxt     = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.tick_inc = sts.is_tick;
				state_nxt    = ST_SCAN;
			end
			ST_SCAN: begin
				if (!sts.is_tick && sts.small_period) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = STATUS_SMALL;
					state_nxt       = ST_FIN;
				end else if (sts.is_tick && sts.tick_zero) begin
					state_nxt = ST_FIN;
				end else if (sts.idx_end) begin
					// The whole table has been walked without a match.
					if (!sts.is_tick) begin
						if (sts.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = STATUS_FULL;
						end else begin
							cmd.commit = 1'b1;
						end
					end
					state_nxt = ST_FIN;
				end else begin
					cmd.rd_en = 1'b1;
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					if (sts.rem_zero) begin
						if (sts.is_tick) begin
							cmd.set_hit = 1'b1;
						end else begin
							cmd.set_status  = 1'b1;
							cmd.status_code = STATUS_OVERLAP;
						end
						state_nxt = ST_FIN;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nxt   = ST_SCAN;
					end
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: design/periodic_tick_dispatcher_core.sv
// Periodic tick dispatcher.
// Input beats arrive on s_*: tuser[0] selects an add (0) or a one millisecond
// tick (1), and tdata carries the period for an add. Every input beat yields
// exactly one output beat on m_*, carrying the status, the fired flag and slot,
// and the tick counter after the item.
// One item is in flight at a time. Each stored entry examined costs a table
// read and a 32-step serial remainder; a full table holds 64 entries by
// default. A tick stops at its first matching slot, an add at its first
// overlap; a small period or a counter that wraps to zero skips the walk.
// The result sits in an output register, so s_tready returns as soon as the
// result has been loaded, even while m_tready is low. A stalled receiver only
// holds the block once a second result is ready to be loaded.
// Reset clears the entry count, the tick counter and the wrap bound; the
// period table itself needs no clearing as only written entries are read.
`default_nettype none
module periodic_tick_dispatcher_core #(
	parameter int unsigned SLOTS = ptd_pkg::SLOTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [ptd_pkg::DATA_W-1:0]  s_tdata,  // [31:0] period
	input  wire logic [0:0]                  s_tuser,  // [0] action
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// [1:0] status, [2] fired, [8:3] fired_slot, [40:9] elapsed, rest zero
	output logic [ptd_pkg::OUT_W-1:0]        m_tdata
);
	import ptd_pkg::*;

	`include "periodic_tick_dispatcher_core_assert.svh"

	ptd_cmd_t          cmd;
	ptd_sts_t          sts;
	logic [STATUS_W-1:0] out_status;
	logic              out_fired;
	logic [SLOT_W-1:0] out_slot;
	logic [DATA_W-1:0] out_elapsed;

	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptd_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_action   (s_tuser[0]),
		.in_period   (s_tdata),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_status  (out_status),
		.out_fired   (out_fired),
		.out_slot    (out_slot),
		.out_elapsed (out_elapsed)
	);

	assign m_tdata = {(OUT_W - DATA_W - SLOT_W - 1 - STATUS_W)'(0),
		out_elapsed, out_slot, out_fired, out_status};

	`PTD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
		"input accepted while an item is still in progress")
	`PTD_ASSERT_IMPL(a_commit_not_full, cmd.commit, !sts.full,
		"period stored into a full table")
	`PTD_ASSERT_IMPL(a_no_result_overwrite, cmd.out_load, sts.out_free,
		"result loaded over one still waiting")
	`PTD_ASSERT_IMPL(a_fired_status_ok, m_tvalid && m_tdata[2],
		m_tdata[1:0] == STATUS_OK, "fired result with nonzero status")

endmodule
`default_nettype wire

// File: dv/tb_top.sv
module tb_top;
	import ptd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 10_000_000;
	localparam int unsigned ITEMS_PER_PHASE = 40;
	localparam int unsigned TAIL_CYCLES = 100;

	typedef struct packed {
		status_t     status;
		logic        fired;
		logic [5:0]  slot;
		logic [31:0] elapsed;
	} dispatch_result_t;

	typedef struct packed {
		action_t          act;
		logic [31:0]      period;
		logic             typed;
		dispatch_result_t want;
	} dir_row_t;

	localparam dispatch_result_t ZERO_RES  = '{STATUS_OK, 1'b0, 6'd0, 32'd0};
	localparam dispatch_result_t SMALL_RES = '{STATUS_SMALL, 1'b0, 6'd0, 32'd0};
	localparam dispatch_result_t OVLP_RES  = '{STATUS_OVERLAP, 1'b0, 6'd0, 32'd0};

	// Rows marked typed carry an expectation worked out by hand; the rest rely on
	// the predictor. The counter stays at zero until the first tick after entries exist.
	localparam int unsigned DIR_ROWS = 25;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{ACT_TICK, 32'd0,          1'b1, ZERO_RES},   // empty table: counter clears at once
		'{ACT_ADD,  32'd0,          1'b1, SMALL_RES},
		'{ACT_ADD,  32'd1,          1'b1, SMALL_RES},
		'{ACT_TICK, 32'hFFFFFFFF,   1'b1, ZERO_RES},   // period ignored on a tick
		'{ACT_ADD,  32'd6,          1'b1, ZERO_RES},
		'{ACT_ADD,  32'd3,          1'b1, OVLP_RES},   // new period divides a stored one
		'{ACT_ADD,  32'd12,         1'b1, OVLP_RES},   // stored period divides the new one
		'{ACT_ADD,  32'd6,          1'b1, OVLP_RES},   // equal period
		'{ACT_ADD,  32'd10,         1'b1, ZERO_RES},
		'{ACT_ADD,  32'd15,         1'b0, ZERO_RES},
		'{ACT_ADD,  32'hFFFFFFFF,   1'b1, OVLP_RES},   // multiple of 15
		'{ACT_ADD,  32'hFFFFFFF0,   1'b1, OVLP_RES},   // multiple of 6
		'{ACT_TICK, 32'd0,          1'b0, ZERO_RES},
		'{ACT_TICK, 32'd0,          1'b0, ZERO_RES},
		'{ACT_TICK, 32'hAAAAAAAA,   1'b0, ZERO_RES},
		'{ACT_TICK, 32'd0,          1'b0, ZERO_RES},
		'{ACT_TICK, 32'h55555555,   1'b0, ZERO_RES},
		'{ACT_TICK, 32'd0,          1'b0, ZERO_RES},
		'{ACT_TICK, 32'd0,          1'b0, ZERO_RES},
		'{ACT_TICK, 32'd0,          1'b0, ZERO_RES},
		'{ACT_TICK, 32'd0,          1'b0, ZERO_RES},
		'{ACT_TICK, 32'd0,          1'b0, ZERO_RES},
		'{ACT_TICK, 32'd0,          1'b0, ZERO_RES},
		'{ACT_TICK, 32'd0,          1'b0, ZERO_RES},
		'{ACT_TICK, 32'd0,          1'b0, ZERO_RES}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	// Shadow copy of the dispatcher state.
	logic [31:0] tbl_periods [SLOTS_DEF];
	int unsigned tbl_count = 0;
	logic [31:0] tick_ctr = '0;
	logic [31:0] wrap_limit = '0;

	dispatch_result_t pending_results [$];
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned sink_stall_pct = 0;

	periodic_tick_dispatcher_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] period
		.s_tuser  (s_tuser),   // [0] action
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		// [1:0] status, [2] fired, [8:3] fired_slot, [40:9] elapsed, rest zero
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Verdict of an add against the current table, without storing anything.
	function automatic status_t add_verdict(logic [31:0] p);
		if (p < 32'd2)
			return STATUS_SMALL;
		for (int unsigned i = 0; i < tbl_count; i++) begin
			if (p % tbl_periods[i] == 0 || tbl_periods[i] % p == 0)
				return STATUS_OVERLAP;
		end
		if (tbl_count >= SLOTS_DEF)
			return STATUS_FULL;
		return STATUS_OK;
	endfunction

	function automatic dispatch_result_t apply_item(action_t act, logic [31:0] p);
		dispatch_result_t res;
		logic [31:0] half;
		res = ZERO_RES;
		if (act == ACT_ADD) begin
			res.status = add_verdict(p);
			if (res.status == STATUS_OK) begin
				tbl_periods[tbl_count] = p;
				tbl_count++;
				if (p > wrap_limit)
					wrap_limit = p;
			end
		end else begin
			tick_ctr = tick_ctr + 32'd1;
			if (tick_ctr != 0) begin
				for (int unsigned i = 0; i < tbl_count; i++) begin
					half = tbl_periods[i] / 2;
					if (tick_ctr % half == 0) begin
						res.fired = 1'b1;
						res.slot = 6'(i);
						break;
					end
				end
			end
			if (tick_ctr > wrap_limit)
				tick_ctr = '0;
		end
		res.elapsed = tick_ctr;
		return res;
	endfunction

	// Offers one beat, with random idle cycles first, and leaves tvalid high
	// after acceptance so back-to-back beats follow without a gap in tvalid.
	task automatic send_item(action_t act, logic [31:0] p, logic typed, dispatch_result_t want);
		dispatch_result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
		predicted = apply_item(act, p);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("result %0d: %s mismatch, got %0h, expected %0h", results_seen, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		dispatch_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", 64'(m_tdata), '0);
			end else begin
				exp_res = pending_results.pop_front();
				if (m_tdata[1:0] !== exp_res.status)
					report_mismatch("status", 64'(m_tdata[1:0]), 64'(exp_res.status));
				if (m_tdata[2] !== exp_res.fired)
					report_mismatch("fired", 64'(m_tdata[2]), 64'(exp_res.fired));
				if (m_tdata[8:3] !== exp_res.slot)
					report_mismatch("fired_slot", 64'(m_tdata[8:3]), 64'(exp_res.slot));
				if (m_tdata[40:9] !== exp_res.elapsed)
					report_mismatch("elapsed", 64'(m_tdata[40:9]), 64'(exp_res.elapsed));
				if (m_tdata[OUT_W-1:41] !== '0)
					report_mismatch("padding", 64'(m_tdata[OUT_W-1:41]), '0);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int unsigned idle_plan [4][2];
		int unsigned pick;
		action_t act;
		logic [31:0] p;
		logic [31:0] s;
		logic [31:0] cand;

		idle_plan = '{'{0, 0}, '{77, 0}, '{0, 77}, '{21, 21}};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned r = 0; r < DIR_ROWS; r++)
			send_item(DIRECTED[r].act, DIRECTED[r].period, DIRECTED[r].typed, DIRECTED[r].want);

		for (int unsigned ph = 0; ph < 4; ph++) begin
			sender_idle_pct = idle_plan[ph][0];
			sink_stall_pct = idle_plan[ph][1];
			for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				act = ACT_ADD;
				p = $urandom;
				if (pick < 55) begin
					act = ACT_TICK;
				end else if (pick < 72) begin
					// Fresh small period; the table is kept small here so scans stay short.
					p = $urandom_range(255, 2);
					if (tbl_count >= 32)
						act = ACT_TICK;
				end else if (pick < 88) begin
					// Multiple of a stored period, which reaches the high bits of an add.
					if (tbl_count != 0) begin
						s = tbl_periods[$urandom_range(tbl_count - 1)];
						p = s * $urandom_range(32'hFFFFFFFF / s, 1);
					end else begin
						p = $urandom_range(1);
					end
				end else if (pick < 94) begin
					p = $urandom_range(1);
				end else if (add_verdict(p) == STATUS_OK) begin
					// A large accepted period would freeze the wrap bound, so send a tick.
					act = ACT_TICK;
				end
				send_item(act, p, 1'b0, ZERO_RES);
			end
			drain_results();
		end

		// Fill the table with periods near the top of the range, which cannot
		// divide one another, then hit the full-table case.
		sender_idle_pct = 0;
		sink_stall_pct = 0;
		send_item(ACT_ADD, 32'h80000000, 1'b0, ZERO_RES);
		cand = 32'hFFFFFFFF;
		while (tbl_count < SLOTS_DEF) begin
			if (add_verdict(cand) == STATUS_OK)
				send_item(ACT_ADD, cand, 1'b0, ZERO_RES);
			cand--;
		end
		while (add_verdict(cand) != STATUS_FULL)
			cand--;
		send_item(ACT_ADD, cand, 1'b0, ZERO_RES);
		send_item(ACT_ADD, 32'd0, 1'b0, ZERO_RES);
		send_item(ACT_ADD, tbl_periods[SLOTS_DEF - 1], 1'b0, ZERO_RES);
		repeat (4)
			send_item(ACT_TICK, $urandom, 1'b0, ZERO_RES);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/ptd_pkg.sv
design/ptd_mod.sv
design/ptd_dp.sv
design/ptd_ctrl.sv
design/periodic_tick_dispatcher_core.sv
dv/tb_top.sv
